// ===== rtl/firf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// firf_pkg
// Shared types and constants for the FIR filter with flush tail.
// ----------------------------------------------------------------------------
package firf_pkg;

  localparam int TAPS      = 8;                 // filter length, 2..8
  localparam int MAX_TAPS  = 8;                 // coefficient registers / tree width
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W; // 32
  localparam int PAIR_W    = PROD_W + 1;        // 33
  localparam int QUAD_W    = PROD_W + 2;        // 34
  localparam int OUT_W     = 35;
  localparam int CFG_IDX_W = 3;
  localparam int FLUSH_W   = $clog2(TAPS);

  localparam logic [FLUSH_W-1:0] FLUSH_LEN  = FLUSH_W'(TAPS - 1);
  localparam logic [FLUSH_W-1:0] FLUSH_LAST = FLUSH_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    burst_end;
  } out_item_t;

  // One filter step issued by the sequencer into the MAC pipeline.
  typedef struct packed {
    logic vld;
    logic burst_end;
  } step_t;

  typedef logic signed [TAPS-1:0][SAMPLE_W-1:0]     tap_vec_t;
  typedef logic signed [MAX_TAPS-1:0][COEF_W-1:0]   coef_vec_t;

endpackage : firf_pkg
`default_nettype wire

// ===== rtl/fir_filter_with_flush_unit.sv =====
`default_nettype none
// Path: an input beat passes the two-entry queue, the sequencer step register
// and the product, pair, quad and output registers of the MAC pipeline.
// Throughput: one sample per cycle while the pipeline advances; after a final sample
// the sequencer issues TAPS-1 flush steps and holds the input queue meanwhile.
// The MAC pipeline stalls as a whole only when the output register is full and out_ready is low.
// Reset (synchronous, active low) clears coefficients, delay line and queues.
// ----------------------------------------------------------------------------
// fir_filter_with_flush_unit
// Direct-form FIR filter with zero-input tail flush on the final sample.
// ----------------------------------------------------------------------------
module fir_filter_with_flush_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire firf_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output firf_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [firf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [firf_pkg::COEF_W-1:0]    cfg_wdata
);

  firf_pkg::coef_vec_t coef_r;
  firf_pkg::in_item_t  q_item;
  logic                q_valid;
  logic                q_pop;
  logic                adv;
  firf_pkg::step_t     step;
  firf_pkg::tap_vec_t  taps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      coef_r[cfg_idx] <= cfg_wdata;
    end
  end

  firf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  firf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .step    (step),
    .taps    (taps)
  );

  firf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .taps      (taps),
    .coefs     (coef_r),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : fir_filter_with_flush_unit
`default_nettype wire

// ===== rtl/firf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// firf_front
// Input side: accepts samples into a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module firf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire firf_pkg::in_item_t in_data,
  output logic                   q_valid,
  output firf_pkg::in_item_t     q_item,
  input  wire logic              q_pop
);

  firf_pkg::in_item_t mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;
  logic               pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule : firf_front
`default_nettype wire

// ===== rtl/firf_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// firf_seq
// Back-end sequencer: owns the delay line, issues at most one valid step per advance and
// runs the zero-input flush after a final sample.
// ----------------------------------------------------------------------------
module firf_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               q_valid,
  input  wire firf_pkg::in_item_t q_item,
  output logic                    q_pop,
  output firf_pkg::step_t         step,
  output firf_pkg::tap_vec_t      taps
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                           state_r, state_nxt;
  logic [firf_pkg::FLUSH_W-1:0]   cnt_r, cnt_nxt;
  firf_pkg::tap_vec_t             dly_r, dly_nxt;
  firf_pkg::step_t                step_r, step_nxt;
  logic                           shift;
  logic signed [firf_pkg::SAMPLE_W-1:0] shift_val;

  assign q_pop = adv && (state_r == ST_RUN) && q_valid;
  assign step  = step_r;
  assign taps  = dly_r;

  // After TAPS-1 zero shifts only the oldest entry is nonzero, and the next
  // shift drops it, so the post-burst clear needs no extra pass.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift     = 1'b0;
    shift_val = '0;
    step_nxt  = step_r;
    if (adv) begin
      step_nxt = '0;
      unique case (state_r)
        ST_RUN: begin
          if (q_valid) begin
            shift     = 1'b1;
            shift_val = q_item.sample;
            step_nxt.vld = 1'b1;
            if (q_item.final_sample) begin
              state_nxt = ST_FLUSH;
              cnt_nxt   = firf_pkg::FLUSH_LEN;
            end
          end
        end
        ST_FLUSH: begin
          shift        = 1'b1;
          step_nxt.vld = 1'b1;
          cnt_nxt      = cnt_r - firf_pkg::FLUSH_W'(1);
          if (cnt_r == firf_pkg::FLUSH_LAST) begin
            step_nxt.burst_end = 1'b1;
            state_nxt          = ST_RUN;
          end
        end
        default: state_nxt = ST_RUN;
      endcase
    end
    dly_nxt = dly_r;
    if (shift) begin
      for (int k = firf_pkg::TAPS - 1; k > 0; k--) begin
        dly_nxt[k] = dly_r[k-1];
      end
      dly_nxt[0] = shift_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
      dly_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dly_r   <= dly_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule : firf_seq
`default_nettype wire

// ===== rtl/firf_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// firf_mac
// Multiply and adder-tree pipeline with the output register. The whole
// pipeline advances together when the output register can move.
// ----------------------------------------------------------------------------
module firf_mac (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire firf_pkg::step_t     step,
  input  wire firf_pkg::tap_vec_t  taps,
  input  wire firf_pkg::coef_vec_t coefs,
  output logic                     adv,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output firf_pkg::out_item_t      out_data
);

  logic signed [firf_pkg::MAX_TAPS-1:0][firf_pkg::PROD_W-1:0] prod_c;
  logic signed [firf_pkg::MAX_TAPS-1:0][firf_pkg::PROD_W-1:0] prod_r;
  logic signed [3:0][firf_pkg::PAIR_W-1:0]                   pair_r;
  logic signed [1:0][firf_pkg::QUAD_W-1:0]                   quad_r;
  firf_pkg::step_t     s1_r, s2_r, s3_r;
  firf_pkg::out_item_t out_r;
  logic                out_vld_r;

  assign adv       = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // elements of a packed vector select as unsigned, so sign is restored here
  for (genvar k = 0; k < firf_pkg::MAX_TAPS; k++) begin : g_mul
    if (k < firf_pkg::TAPS) begin : g_on
      assign prod_c[k] = firf_pkg::PROD_W'($signed(taps[k]) * $signed(coefs[k]));
    end else begin : g_off
      assign prod_c[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_r      <= '0;
      s3_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_r      <= step;
      s2_r      <= s1_r;
      s3_r      <= s2_r;
      out_vld_r <= s3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_c;
      for (int i = 0; i < 4; i++) begin
        pair_r[i] <= firf_pkg::PAIR_W'($signed(prod_r[2*i])) +
                     firf_pkg::PAIR_W'($signed(prod_r[2*i+1]));
      end
      for (int i = 0; i < 2; i++) begin
        quad_r[i] <= firf_pkg::QUAD_W'($signed(pair_r[2*i])) +
                     firf_pkg::QUAD_W'($signed(pair_r[2*i+1]));
      end
      out_r.filtered  <= firf_pkg::OUT_W'($signed(quad_r[0])) +
                         firf_pkg::OUT_W'($signed(quad_r[1]));
      out_r.burst_end <= s3_r.burst_end;
    end
  end

endmodule : firf_mac
`default_nettype wire
